/* hdl/terrain_grid_max_elevation_query_macros.svh */
// ---------------------------------------------------------------------------
// terrain grid max elevation query assertion macros
// shared property forms, sampled on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef TERRAIN_GRID_MAX_ELEVATION_QUERY_MACROS_SVH
`define TERRAIN_GRID_MAX_ELEVATION_QUERY_MACROS_SVH

// condition implies consequence in the same cycle
`define TGMEQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgmeq same-cycle check failed");

// condition implies consequence in the next cycle
`define TGMEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgmeq next-cycle check failed");

`endif

/* hdl/tgmeq_pkg.sv */
// ---------------------------------------------------------------------------
// tgmeq_pkg
// types and fixed constants shared by the elevation query block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgmeq_pkg;

  localparam int OPCODE_W  = 2;
  localparam int IDX_W     = 10;
  localparam int ELEV_W    = 16;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_EMPTY  = 2'd2;

  localparam logic [CFG_W-1:0] TILE_SIZE_RST = 11'd1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_POINT = 2'd1,
    OP_WIDE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CLAMP,
    ST_READ
  } state_t;

  // neighbor offset along one axis
  typedef enum logic [1:0] {
    OFF_NEG,
    OFF_ZERO,
    OFF_POS
  } off_t;

  typedef struct packed {
    logic wr;
    logic empty_res;
    logic load;
    logic scale;
    logic clamp;
    logic rd;
    logic wide;
    off_t dx;
    off_t dy;
    logic first;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tile_empty;
  } dp_status_t;

endpackage

/* hdl/tgmeq_ram.sv */
// ---------------------------------------------------------------------------
// tgmeq_ram
// single port ram, write or registered read; rdata holds during a write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgmeq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tgmeq_ctrl.sv */
// ---------------------------------------------------------------------------
// tgmeq_ctrl
// request sequencer: index scaling, clamping and the 3x3 read walk
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "terrain_grid_max_elevation_query_macros.svh"

module tgmeq_ctrl
  import tgmeq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OPCODE_W-1:0] opcode,
  input  dp_status_t          status,
  output logic                busy,
  output ctrl_cmd_t           cmd
);

  state_t state_r, state_nxt;
  logic   wide_r, wide_nxt;
  off_t   dx_r, dx_nxt;
  off_t   dy_r, dy_nxt;
  logic   accept;
  logic   walk_first;
  logic   walk_last;

  assign accept     = start && !busy;
  assign walk_first = wide_r ? (dx_r == OFF_NEG && dy_r == OFF_NEG) : 1'b1;
  assign walk_last  = wide_r ? (dx_r == OFF_POS && dy_r == OFF_POS) : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wide_r  <= 1'b0;
      dx_r    <= OFF_NEG;
      dy_r    <= OFF_NEG;
    end else begin
      state_r <= state_nxt;
      wide_r  <= wide_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !status.tile_empty &&
            (opcode == OP_POINT || opcode == OP_WIDE)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_READ;
      ST_READ: begin
        if (walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // mode and neighbor counters, dy inner, dx outer
  always_comb begin
    wide_nxt = wide_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    if (state_r == ST_IDLE && accept) begin
      wide_nxt = (opcode == OP_WIDE);
      dx_nxt   = OFF_NEG;
      dy_nxt   = OFF_NEG;
    end else if (state_r == ST_READ && wide_r) begin
      case (dy_r)
        OFF_NEG:  dy_nxt = OFF_ZERO;
        OFF_ZERO: dy_nxt = OFF_POS;
        default: begin
          dy_nxt = OFF_NEG;
          case (dx_r)
            OFF_NEG:  dx_nxt = OFF_ZERO;
            OFF_ZERO: dx_nxt = OFF_POS;
            default:  dx_nxt = OFF_NEG;
          endcase
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    busy          = 1'b0;
    cmd.wr        = 1'b0;
    cmd.empty_res = 1'b0;
    cmd.load      = 1'b0;
    cmd.scale     = 1'b0;
    cmd.clamp     = 1'b0;
    cmd.rd        = 1'b0;
    cmd.wide      = wide_r;
    cmd.dx        = wide_r ? dx_r : OFF_ZERO;
    cmd.dy        = wide_r ? dy_r : OFF_ZERO;
    cmd.first     = walk_first;
    cmd.last      = walk_last;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_WRITE: cmd.wr = 1'b1;
            OP_POINT, OP_WIDE: begin
              cmd.empty_res = status.tile_empty;
              cmd.load      = !status.tile_empty;
            end
            default: ;
          endcase
        end
      end
      ST_SCALE: begin
        busy      = 1'b1;
        cmd.scale = 1'b1;
      end
      ST_CLAMP: begin
        busy      = 1'b1;
        cmd.clamp = 1'b1;
      end
      ST_READ: begin
        busy   = 1'b1;
        cmd.rd = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  `TGMEQ_ASSERT_NEXT(a_last_read_ends, cmd.rd && cmd.last, state_r == ST_IDLE)
  `TGMEQ_ASSERT_NEXT(a_query_starts, cmd.load, state_r == ST_SCALE && busy)
  `TGMEQ_ASSERT_SAME(a_one_cmd,
    1'b1, $onehot0({cmd.wr, cmd.empty_res, cmd.load, cmd.scale, cmd.clamp, cmd.rd}))

endmodule

/* hdl/tgmeq_dp.sv */
// ---------------------------------------------------------------------------
// tgmeq_dp
// tile registers, index scaling and clamping, sample store, result stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "terrain_grid_max_elevation_query_macros.svh"

module tgmeq_dp
  import tgmeq_pkg::*;
#(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [IDX_W-1:0]         in_write_row,
  input  logic [IDX_W-1:0]         in_write_col,
  input  logic signed [ELEV_W-1:0] in_write_value,
  input  logic [FRACTION_BITS-1:0] in_lat_fraction,
  input  logic [FRACTION_BITS-1:0] in_lon_fraction,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               status,
  output logic                     out_strobe,
  output logic                     out_valid_res,
  output logic [IDX_W-1:0]         out_sample_col,
  output logic [IDX_W-1:0]         out_sample_row,
  output logic signed [ELEV_W-1:0] out_sample_elev,
  output logic signed [ELEV_W-1:0] out_peak_elev,
  output logic                     out_last
);

  localparam int SZW_W  = $clog2(MAX_WIDTH + 1);
  localparam int SZH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PCOL_W = FRACTION_BITS + SZW_W;
  localparam int PROW_W = FRACTION_BITS + SZH_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CFG_W-1:0] tile_w_r, tile_h_r;
  logic             tile_empty_r;

  logic [SZW_W-1:0] w_eff, w_m1;
  logic [SZH_W-1:0] h_eff, h_m1;

  logic [FRACTION_BITS-1:0] lat_r, lon_r;
  logic [PCOL_W-1:0]        pcol_r;
  logic [PROW_W-1:0]        prow_r;
  logic [SZW_W-1:0]         cidx;
  logic [SZH_W-1:0]         ridx;
  logic [COL_W-1:0]         cx_r, col_sel;
  logic [ROW_W-1:0]         cy_r, row_sel;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr, waddr, raddr;
  logic [ELEV_W-1:0] ram_q;

  logic                     strobe_r, valid_r, first_r, last_r;
  logic [IDX_W-1:0]         col_r, row_r;
  logic signed [ELEV_W-1:0] max_r, max_cur, q_s;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_w_r     <= TILE_SIZE_RST;
      tile_h_r     <= TILE_SIZE_RST;
      tile_empty_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TILE_WIDTH:  tile_w_r     <= cfg_data;
        CFG_TILE_HEIGHT: tile_h_r     <= cfg_data;
        CFG_TILE_EMPTY:  tile_empty_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign status.tile_empty = tile_empty_r;

  // effective tile size: zero acts as one, clipped to the store
  always_comb begin
    if (32'(tile_w_r) > 32'(MAX_WIDTH)) begin
      w_eff = SZW_W'(MAX_WIDTH);
    end else if (tile_w_r == '0) begin
      w_eff = SZW_W'(1);
    end else begin
      w_eff = SZW_W'(tile_w_r);
    end
    if (32'(tile_h_r) > 32'(MAX_HEIGHT)) begin
      h_eff = SZH_W'(MAX_HEIGHT);
    end else if (tile_h_r == '0) begin
      h_eff = SZH_W'(1);
    end else begin
      h_eff = SZH_W'(tile_h_r);
    end
  end

  assign w_m1 = w_eff - SZW_W'(1);
  assign h_m1 = h_eff - SZH_W'(1);

  // fraction capture, scaling product, clamp to tile
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_r <= in_lat_fraction;
      lon_r <= in_lon_fraction;
    end
    if (cmd.scale) begin
      pcol_r <= PCOL_W'(lon_r) * PCOL_W'(w_eff)
              + (cmd.wide ? (PCOL_W'(1) << (FRACTION_BITS - 1)) : '0);
      prow_r <= PROW_W'(lat_r) * PROW_W'(h_eff)
              + (cmd.wide ? (PROW_W'(1) << (FRACTION_BITS - 1)) : '0);
    end
    if (cmd.clamp) begin
      cx_r <= COL_W'((cidx > w_m1) ? w_m1 : cidx);
      cy_r <= ROW_W'((ridx > h_m1) ? h_m1 : ridx);
    end
  end

  assign cidx = pcol_r[PCOL_W-1:FRACTION_BITS];
  assign ridx = prow_r[PROW_W-1:FRACTION_BITS];

  // neighbor index, held inside the tile
  always_comb begin
    case (cmd.dx)
      OFF_NEG:  col_sel = (cx_r == '0) ? cx_r : cx_r - COL_W'(1);
      OFF_POS:  col_sel = (SZW_W'(cx_r) == w_m1) ? cx_r : cx_r + COL_W'(1);
      default:  col_sel = cx_r;
    endcase
    case (cmd.dy)
      OFF_NEG:  row_sel = (cy_r == '0) ? cy_r : cy_r - ROW_W'(1);
      OFF_POS:  row_sel = (SZH_W'(cy_r) == h_m1) ? cy_r : cy_r + ROW_W'(1);
      default:  row_sel = cy_r;
    endcase
  end

  // sample store, writes outside the store are dropped
  assign ram_we = cmd.wr && (32'(in_write_row) < 32'(MAX_HEIGHT))
                         && (32'(in_write_col) < 32'(MAX_WIDTH));
  assign waddr  = ADDR_W'(32'(in_write_row) * 32'(MAX_WIDTH) + 32'(in_write_col));
  assign raddr  = ADDR_W'(32'(row_sel) * 32'(MAX_WIDTH) + 32'(col_sel));
  assign ram_addr = ram_we ? waddr : raddr;

  tgmeq_ram #(
    .WIDTH (ELEV_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_write_value),
    .rdata (ram_q)
  );

  // result stage, lines up with the registered ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.rd || cmd.empty_res;
    end
  end

  always_ff @(posedge clk) begin
    valid_r <= cmd.rd;
    first_r <= cmd.first;
    last_r  <= cmd.rd ? cmd.last : 1'b1;
    col_r   <= cmd.rd ? IDX_W'(col_sel) : '0;
    row_r   <= cmd.rd ? IDX_W'(row_sel) : '0;
    if (strobe_r && valid_r) begin
      max_r <= max_cur;
    end
  end

  assign q_s     = $signed(ram_q);
  assign max_cur = (first_r || q_s > max_r) ? q_s : max_r;

  assign out_strobe      = strobe_r;
  assign out_valid_res   = valid_r;
  assign out_sample_col  = col_r;
  assign out_sample_row  = row_r;
  assign out_sample_elev = valid_r ? q_s : '0;
  assign out_peak_elev   = valid_r ? max_cur : '0;
  assign out_last        = last_r;

  `TGMEQ_ASSERT_NEXT(a_read_gives_result, cmd.rd, out_strobe && out_valid_res)
  `TGMEQ_ASSERT_SAME(a_invalid_is_last, out_strobe && !out_valid_res, out_last)
  `TGMEQ_ASSERT_SAME(a_no_write_in_walk, cmd.rd, !ram_we)

endmodule

/* hdl/terrain_grid_max_elevation_query.sv */
// ---------------------------------------------------------------------------
// terrain_grid_max_elevation_query
// elevation tile store with point and 3x3 neighborhood maximum queries
//
//   channel  | handshake                 | moves
//   ---------+---------------------------+------------------------------
//   in_      | start high, busy low      | one request
//   out_     | out_strobe, one cycle     | one result, cannot be stalled
//   cfg_     | cfg_wr_en, no wait        | one register write
//
// a write request is stored in the cycle it is accepted and busy stays low.
// an empty-tile query gives its single result in the next cycle.
// point and wide queries load their fractions when accepted, then pass the scale
// and clamp stages plus one read per neighbor through the single sample ram port.
// each result comes in the cycle after its read; there is no clearing pass after
// reset, the store holds unknown samples until written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module terrain_grid_max_elevation_query
  import tgmeq_pkg::*;
#(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPCODE_W-1:0]      in_opcode,
  input  logic [IDX_W-1:0]         in_write_row,
  input  logic [IDX_W-1:0]         in_write_col,
  input  logic signed [ELEV_W-1:0] in_write_value,
  input  logic [FRACTION_BITS-1:0] in_lat_fraction,
  input  logic [FRACTION_BITS-1:0] in_lon_fraction,
  output logic                     out_strobe,
  output logic                     out_valid_res,
  output logic [IDX_W-1:0]         out_sample_col,
  output logic [IDX_W-1:0]         out_sample_row,
  output logic signed [ELEV_W-1:0] out_sample_elev,
  output logic signed [ELEV_W-1:0] out_peak_elev,
  output logic                     out_last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tgmeq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  tgmeq_dp #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_write_row    (in_write_row),
    .in_write_col    (in_write_col),
    .in_write_value  (in_write_value),
    .in_lat_fraction (in_lat_fraction),
    .in_lon_fraction (in_lon_fraction),
    .cmd             (cmd),
    .status          (status),
    .out_strobe      (out_strobe),
    .out_valid_res   (out_valid_res),
    .out_sample_col  (out_sample_col),
    .out_sample_row  (out_sample_row),
    .out_sample_elev (out_sample_elev),
    .out_peak_elev   (out_peak_elev),
    .out_last        (out_last)
  );

endmodule

/* tb/sv/tb_terrain_grid_max_elevation_query.sv */
// ---------------------------------------------------------------------------
// tb_terrain_grid_max_elevation_query
// drives write, point and 3x3 maximum requests into the elevation tile block
// and checks every result against an in-bench prediction of the tile store,
// over several tile sizes (zero, one, oversized, full) and the empty flag
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_terrain_grid_max_elevation_query;
  import tgmeq_pkg::*;

  localparam int TILE_MAX     = 1024;
  localparam int FRAC_W       = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         col;
    logic [IDX_W-1:0]         row;
    logic signed [ELEV_W-1:0] elev;
    logic signed [ELEV_W-1:0] peak;
    logic                     last;
  } elev_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic start;
  logic busy;
  logic [OPCODE_W-1:0] in_opcode;
  logic [IDX_W-1:0] in_write_row;
  logic [IDX_W-1:0] in_write_col;
  logic signed [ELEV_W-1:0] in_write_value;
  logic [FRAC_W-1:0] in_lat_fraction;
  logic [FRAC_W-1:0] in_lon_fraction;
  logic out_strobe;
  logic out_valid_res;
  logic [IDX_W-1:0] out_sample_col;
  logic [IDX_W-1:0] out_sample_row;
  logic signed [ELEV_W-1:0] out_sample_elev;
  logic signed [ELEV_W-1:0] out_peak_elev;
  logic out_last;

  // predicted tile contents and registers
  logic signed [ELEV_W-1:0] stored_elev [int unsigned];
  logic [CFG_W-1:0] tile_w_cfg;
  logic [CFG_W-1:0] tile_h_cfg;
  logic tile_empty_cfg;

  elev_result_t pending_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  terrain_grid_max_elevation_query dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_write_row    (in_write_row),
    .in_write_col    (in_write_col),
    .in_write_value  (in_write_value),
    .in_lat_fraction (in_lat_fraction),
    .in_lon_fraction (in_lon_fraction),
    .out_strobe      (out_strobe),
    .out_valid_res   (out_valid_res),
    .out_sample_col  (out_sample_col),
    .out_sample_row  (out_sample_row),
    .out_sample_elev (out_sample_elev),
    .out_peak_elev   (out_peak_elev),
    .out_last        (out_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned tile_size(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > TILE_MAX) return TILE_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned frac_to_index(input logic [FRAC_W-1:0] frac,
                                                input int unsigned size,
                                                input bit round_half);
    int unsigned p;
    int unsigned idx;
    p = frac * size;
    if (round_half) p += 1 << (FRAC_W - 1);
    idx = p >> FRAC_W;
    if (idx > size - 1) idx = size - 1;
    return idx;
  endfunction

  // store addresses read by a query, in the order the block reads them
  function automatic void query_addrs(input logic [OPCODE_W-1:0] op,
                                      input logic [FRAC_W-1:0] lat,
                                      input logic [FRAC_W-1:0] lon,
                                      output int unsigned addrs[$]);
    int unsigned w;
    int unsigned h;
    int cx;
    int cy;
    int x;
    int y;
    addrs = {};
    w = tile_size(tile_w_cfg);
    h = tile_size(tile_h_cfg);
    if (op == OP_POINT) begin
      addrs.push_back(frac_to_index(lat, h, 1'b0) * TILE_MAX + frac_to_index(lon, w, 1'b0));
    end else begin
      cx = frac_to_index(lon, w, 1'b1);
      cy = frac_to_index(lat, h, 1'b1);
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          x = cx + dx;
          y = cy + dy;
          if (x < 0) x = 0;
          if (x > int'(w) - 1) x = w - 1;
          if (y < 0) y = 0;
          if (y > int'(h) - 1) y = h - 1;
          addrs.push_back(y * TILE_MAX + x);
        end
      end
    end
  endfunction

  function automatic void predict_request(input logic [OPCODE_W-1:0] op,
                                          input logic [IDX_W-1:0] wrow,
                                          input logic [IDX_W-1:0] wcol,
                                          input logic signed [ELEV_W-1:0] wval,
                                          input logic [FRAC_W-1:0] lat,
                                          input logic [FRAC_W-1:0] lon);
    int unsigned addrs[$];
    elev_result_t r;
    logic signed [ELEV_W-1:0] e;
    logic signed [ELEV_W-1:0] best;
    best = '0;
    case (op)
      OP_WRITE: begin
        stored_elev[wrow * TILE_MAX + wcol] = wval;
      end
      OP_POINT, OP_WIDE: begin
        if (tile_empty_cfg) begin
          r = '0;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          query_addrs(op, lat, lon, addrs);
          foreach (addrs[k]) begin
            e = stored_elev[addrs[k]];
            if (k == 0 || e > best) best = e;
            r.valid = 1'b1;
            r.col   = IDX_W'(addrs[k] % TILE_MAX);
            r.row   = IDX_W'(addrs[k] / TILE_MAX);
            r.elev  = e;
            r.peak  = best;
            r.last  = (k == addrs.size() - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [ELEV_W-1:0] rand_elev();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    return ELEV_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [FRAC_W-1:0] rand_fraction();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 40) return FRAC_W'(32'h8000 + $urandom_range(0, 15) - 8);
    return FRAC_W'($urandom_range(0, 65535));
  endfunction

  // waits for acceptance, then books the request in the prediction
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic [IDX_W-1:0] wrow,
                              input logic [IDX_W-1:0] wcol,
                              input logic signed [ELEV_W-1:0] wval,
                              input logic [FRAC_W-1:0] lat,
                              input logic [FRAC_W-1:0] lon);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_write_row    <= wrow;
    in_write_col    <= wcol;
    in_write_value  <= wval;
    in_lat_fraction <= lat;
    in_lon_fraction <= lon;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(op, wrow, wcol, wval, lat, lon);
  endtask

  // fills any sample the query would read that was never written, then queries
  task automatic query_with_fill(input logic [OPCODE_W-1:0] op,
                                 input logic [FRAC_W-1:0] lat,
                                 input logic [FRAC_W-1:0] lon);
    int unsigned addrs[$];
    if (!tile_empty_cfg) query_addrs(op, lat, lon, addrs);
    foreach (addrs[k]) begin
      if (!stored_elev.exists(addrs[k]))
        send_request(OP_WRITE, IDX_W'(addrs[k] / TILE_MAX), IDX_W'(addrs[k] % TILE_MAX),
                     rand_elev(), FRAC_W'($urandom_range(0, 65535)),
                     FRAC_W'($urandom_range(0, 65535)));
    end
    send_request(op, IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
                 rand_elev(), lat, lon);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a trailing write or unused opcode leaves nothing to wait on
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_tile(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                          input logic empty);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TILE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    tile_w_cfg = w;
    cfg_index <= CFG_TILE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    tile_h_cfg = h;
    cfg_index <= CFG_TILE_EMPTY;
    cfg_data  <= {{(CFG_W-1){1'b0}}, empty};
    @(posedge clk);
    tile_empty_cfg = empty;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_empty_tile_after_reset();
    query_with_fill(OP_POINT, '0, '0);
    query_with_fill(OP_WIDE, '1, '1);
    send_request(OP_UNUSED, '1, '1, 16'sh7fff, '1, '1);
    send_request(OP_WRITE, '1, '1, 16'sh8000, '0, '0);
    query_with_fill(OP_WIDE, 16'h8000, 16'h4000);
  endtask

  task automatic test_small_tile();
    logic signed [ELEV_W-1:0] fill [6];
    fill = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, 16'sd100};
    set_tile(11'd3, 11'd2, 1'b0);
    for (int i = 0; i < 6; i++)
      send_request(OP_WRITE, IDX_W'(i / 3), IDX_W'(i % 3), fill[i], '0, '0);
    query_with_fill(OP_POINT, '0, '0);
    query_with_fill(OP_POINT, '1, '1);
    query_with_fill(OP_POINT, 16'h7fff, 16'h5555);
    query_with_fill(OP_WIDE, '0, '0);
    query_with_fill(OP_WIDE, '1, '1);
    query_with_fill(OP_WIDE, 16'h8000, 16'h8000);
    send_request(OP_UNUSED, '0, '0, '0, '0, '0);
  endtask

  task automatic test_tile_size_limits();
    // zero width acts as one column, oversized height as the full store
    set_tile(11'd0, 11'h7ff, 1'b0);
    query_with_fill(OP_POINT, '1, '1);
    query_with_fill(OP_WIDE, '0, 16'd40000);
    set_tile(11'h7ff, 11'd0, 1'b0);
    query_with_fill(OP_WIDE, '1, '1);
  endtask

  task automatic test_random_traffic(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                     input logic empty, input int n_queries,
                                     input bit back_to_back);
    int done;
    int r;
    done = 0;
    set_tile(w, h, empty);
    no_idle = back_to_back;
    while (done < n_queries) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_request(OP_WRITE, IDX_W'($urandom_range(0, 1023)),
                     IDX_W'($urandom_range(0, 1023)), rand_elev(),
                     FRAC_W'($urandom_range(0, 65535)), FRAC_W'($urandom_range(0, 65535)));
      end else if (r < 13) begin
        send_request(OP_UNUSED, IDX_W'($urandom_range(0, 1023)),
                     IDX_W'($urandom_range(0, 1023)), rand_elev(),
                     FRAC_W'($urandom_range(0, 65535)), FRAC_W'($urandom_range(0, 65535)));
      end else begin
        query_with_fill($urandom_range(0, 1) ? OP_WIDE : OP_POINT,
                        rand_fraction(), rand_fraction());
        done++;
      end
    end
    no_idle = 1'b0;
  endtask

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    elev_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: col %0d row %0d elev %0d",
               out_sample_col, out_sample_row, out_sample_elev);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("valid_res", 32'(want.valid), 32'(out_valid_res));
        check_field("sample_col", 32'(want.col), 32'(out_sample_col));
        check_field("sample_row", 32'(want.row), 32'(out_sample_row));
        check_field("sample_elev", 32'(want.elev), 32'(out_sample_elev));
        check_field("peak_elev", 32'(want.peak), 32'(out_peak_elev));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_TILE_WIDTH;
    cfg_data        <= '0;
    start           <= 1'b0;
    in_opcode       <= OP_WRITE;
    in_write_row    <= '0;
    in_write_col    <= '0;
    in_write_value  <= '0;
    in_lat_fraction <= '0;
    in_lon_fraction <= '0;
    tile_w_cfg      = TILE_SIZE_RST;
    tile_h_cfg      = TILE_SIZE_RST;
    tile_empty_cfg  = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_tile_after_reset();
    test_small_tile();
    test_tile_size_limits();
    test_random_traffic(11'd0, 11'd0, 1'b0, 8, 1'b0);
    test_random_traffic(11'd5, 11'd7, 1'b0, 5, 1'b0);
    test_random_traffic(11'h7ff, 11'h7ff, 1'b0, 2, 1'b1);
    test_random_traffic(11'd1, 11'd1024, 1'b0, 4, 1'b0);
    test_random_traffic(11'd3, 11'd2, 1'b1, 6, 1'b0);
    test_random_traffic(11'd1024, 11'd1, 1'b0, 4, 1'b0);
    test_random_traffic(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)),
                        1'b0, 5, 1'b0);
    test_random_traffic(11'd1024, 11'd1024, 1'b0, 2, 1'b1);

    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
